@@ rtl/core/asvg_pkg.sv @@
package asvg_pkg;

    // Field and datapath widths.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int SEG_W           = 7;
    localparam int COUNT_W         = 7;
    localparam int CENTER_W        = 16;
    localparam int RADIUS_W        = 15;
    localparam int RSUM_W          = RADIUS_W + 1;
    localparam int ANGLE_W         = 9;
    localparam int MAG_W           = 15;
    localparam int QIDX_W          = 7;
    localparam int PROD_W          = 16;
    localparam int QUOT_W          = 8;
    localparam int INDEX_W         = 16;
    localparam int CORNER_W        = 3;
    localparam int COLOR_W         = 24;
    localparam int CHAN_W          = 8;
    localparam int MULT_W          = MAG_W + RSUM_W;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 24;

    // Angle and fixed-point constants.
    localparam int MAX_SEGMENTS    = 127;
    localparam int FULL_TURN       = 360;
    localparam int QUARTER_TURN    = 90;
    localparam int RECIP_SHIFT     = 24;
    localparam int RECIP_W         = 16;
    localparam int RPROD_W         = PROD_W + RECIP_W;
    localparam int RECIP_360       = (1 << RECIP_SHIFT) / FULL_TURN;
    localparam int ROUND_SHIFT     = 14;
    localparam int ROUND_HALF      = 1 << (ROUND_SHIFT - 1);
    localparam int ONE_Q14         = 16384;
    localparam longint unsigned RAD_Q30 = 64'd18740330;
    localparam int LAST_CORNER     = 5;
    localparam int QUEUE_DEPTH     = 2;

    // Reset values of the configuration registers.
    localparam int RESET_SCALE     = 4096;
    localparam int RESET_COUNT     = 36;
    localparam int RESET_COLOR     = 24'hFFFFFF;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X,
        CFG_CENTER_Y,
        CFG_SCALE_X,
        CFG_SCALE_Y,
        CFG_THICKNESS,
        CFG_SEGMENT_COUNT,
        CFG_COLOR_RGB,
        CFG_BASE_INDEX
    } t_cfg_reg;

    // Signed trig value as sign and Q1.14 magnitude.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_trig;

    // One segment's job as handed from the front to the back.
    typedef struct packed {
        t_trig              sin0;
        t_trig              cos0;
        t_trig              sin1;
        t_trig              cos1;
        logic [INDEX_W-1:0] index_base;
    } t_seg_job;

    // Configuration as seen by the datapath; step replaces the segment count.
    typedef struct packed {
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [RADIUS_W-1:0]        scale_x;
        logic [RADIUS_W-1:0]        scale_y;
        logic [RADIUS_W-1:0]        thickness;
        logic [ANGLE_W-1:0]         step;
        logic [COLOR_W-1:0]         color_rgb;
        logic [INDEX_W-1:0]         base_index;
    } t_cfg;

    typedef logic [MAG_W-1:0]   t_qsin_tab [0:QUARTER_TURN];
    typedef logic [ANGLE_W-1:0] t_step_tab [0:(1 << COUNT_W)-1];

    // Quarter-wave sine in Q1.14 from a Taylor series evaluated in Q30.
    function automatic t_qsin_tab build_qsin();
        t_qsin_tab tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        for (int d = 0; d <= QUARTER_TURN; d++) begin
            x    = 64'(d) * RAD_Q30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + term;
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - term;
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + term;
            r    = (sum + 64'd32768) >> 16;
            if (r > 64'(ONE_Q14)) begin
                r = 64'(ONE_Q14);
            end
            tab[d] = MAG_W'(r);
        end
        return tab;
    endfunction

    // Angular step per segment count, found by counting whole steps in a turn.
    function automatic t_step_tab build_step();
        t_step_tab tab;
        int c;
        int s;
        for (int i = 0; i < (1 << COUNT_W); i++) begin
            c = (i > MAX_SEGMENTS) ? MAX_SEGMENTS : i;
            s = 0;
            if (c != 0) begin
                while ((s + 1) * c <= FULL_TURN) begin
                    s = s + 1;
                end
            end
            tab[i] = ANGLE_W'(s);
        end
        return tab;
    endfunction

    localparam t_qsin_tab QSIN     = build_qsin();
    localparam t_step_tab STEP_TAB = build_step();
    localparam logic [ANGLE_W-1:0] RESET_STEP = STEP_TAB[RESET_COUNT];

    // Angle plus a quarter turn, wrapped into one turn.
    function automatic logic [ANGLE_W-1:0] quarter_ahead(input logic [ANGLE_W-1:0] deg);
        logic [ANGLE_W:0] sum;
        sum = {1'b0, deg} + (ANGLE_W+1)'(QUARTER_TURN);
        if (sum >= (ANGLE_W+1)'(FULL_TURN)) begin
            sum = sum - (ANGLE_W+1)'(FULL_TURN);
        end
        return sum[ANGLE_W-1:0];
    endfunction

    // Sine of a whole-degree angle in one turn, by quadrant symmetry.
    function automatic t_trig trig_of(input logic [ANGLE_W-1:0] deg);
        t_trig              t;
        logic [ANGLE_W-1:0] idx;
        if (deg <= ANGLE_W'(QUARTER_TURN)) begin
            idx   = deg;
            t.neg = 1'b0;
        end else if (deg <= ANGLE_W'(2 * QUARTER_TURN)) begin
            idx   = ANGLE_W'(2 * QUARTER_TURN) - deg;
            t.neg = 1'b0;
        end else if (deg <= ANGLE_W'(3 * QUARTER_TURN)) begin
            idx   = deg - ANGLE_W'(2 * QUARTER_TURN);
            t.neg = 1'b1;
        end else begin
            idx   = ANGLE_W'(FULL_TURN) - deg;
            t.neg = 1'b1;
        end
        t.mag = QSIN[idx[QIDX_W-1:0]];
        return t;
    endfunction

endpackage

@@ rtl/core/asvg_seg_if.sv @@
interface asvg_seg_if;
    logic                        valid;
    logic                        ready;
    logic [asvg_pkg::SEG_W-1:0]  segment;

    modport source (output valid, output segment, input ready);
    modport sink   (input valid, input segment, output ready);
endinterface

@@ rtl/core/asvg_vtx_if.sv @@
interface asvg_vtx_if #(
    parameter int COORD_WIDTH = asvg_pkg::COORD_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [COORD_WIDTH-1:0]        vertex_x;
    logic signed [COORD_WIDTH-1:0]        vertex_y;
    logic [asvg_pkg::INDEX_W-1:0]         vertex_index;
    logic [asvg_pkg::CORNER_W-1:0]        corner;
    logic [asvg_pkg::CHAN_W-1:0]          red;
    logic [asvg_pkg::CHAN_W-1:0]          green;
    logic [asvg_pkg::CHAN_W-1:0]          blue;
    logic                                 last;

    modport source (
        output valid, output vertex_x, output vertex_y, output vertex_index,
        output corner, output red, output green, output blue, output last,
        input  ready
    );
    modport sink (
        input  valid, input vertex_x, input vertex_y, input vertex_index,
        input  corner, input red, input green, input blue, input last,
        output ready
    );
endinterface

@@ rtl/core/asvg_front.sv @@
module asvg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asvg_pkg::t_cfg     i_cfg,
    asvg_seg_if.sink           i_seg,
    output logic               o_job_valid,
    output asvg_pkg::t_seg_job o_job,
    input  logic               i_job_ready
);

    logic                               adv;
    logic [asvg_pkg::PROD_W-1:0]        seg_ext;
    logic [asvg_pkg::PROD_W-1:0]        step_ext;
    logic [asvg_pkg::PROD_W-1:0]        n_p0;
    logic [asvg_pkg::INDEX_W-1:0]       seg_idx;

    logic                               r_s1_valid;
    logic [asvg_pkg::PROD_W-1:0]        r_s1_p0;
    logic [asvg_pkg::PROD_W-1:0]        r_s1_p1;
    logic [asvg_pkg::INDEX_W-1:0]       r_s1_index;

    logic                               r_s2_valid;
    logic [asvg_pkg::PROD_W-1:0]        r_s2_p0;
    logic [asvg_pkg::PROD_W-1:0]        r_s2_p1;
    logic [asvg_pkg::QUOT_W-1:0]        r_s2_q0;
    logic [asvg_pkg::QUOT_W-1:0]        r_s2_q1;
    logic [asvg_pkg::INDEX_W-1:0]       r_s2_index;

    logic                               r_s3_valid;
    logic [asvg_pkg::ANGLE_W-1:0]       r_s3_a0;
    logic [asvg_pkg::ANGLE_W-1:0]       r_s3_a1;
    logic [asvg_pkg::INDEX_W-1:0]       r_s3_index;

    // Estimate of p / 360 by reciprocal multiplication; low by at most one.
    function automatic logic [asvg_pkg::QUOT_W-1:0] quot_est(
        input logic [asvg_pkg::PROD_W-1:0] p
    );
        logic [asvg_pkg::RPROD_W-1:0] prod;
        prod = asvg_pkg::RPROD_W'(p) * asvg_pkg::RPROD_W'(asvg_pkg::RECIP_360);
        return asvg_pkg::QUOT_W'(prod >> asvg_pkg::RECIP_SHIFT);
    endfunction

    // Remainder from the estimate, then one correcting subtract.
    function automatic logic [asvg_pkg::ANGLE_W-1:0] rem_fix(
        input logic [asvg_pkg::PROD_W-1:0] p,
        input logic [asvg_pkg::QUOT_W-1:0] q
    );
        logic [asvg_pkg::PROD_W-1:0] rem;
        rem = p - asvg_pkg::PROD_W'(q) * asvg_pkg::PROD_W'(asvg_pkg::FULL_TURN);
        if (rem >= asvg_pkg::PROD_W'(asvg_pkg::FULL_TURN)) begin
            rem = rem - asvg_pkg::PROD_W'(asvg_pkg::FULL_TURN);
        end
        return rem[asvg_pkg::ANGLE_W-1:0];
    endfunction

    // The whole front moves together unless its last stage is blocked.
    assign adv         = !r_s3_valid || i_job_ready;
    assign i_seg.ready = adv;

    assign seg_ext  = asvg_pkg::PROD_W'(i_seg.segment);
    assign step_ext = asvg_pkg::PROD_W'(i_cfg.step);
    assign n_p0     = seg_ext * step_ext;
    assign seg_idx  = asvg_pkg::INDEX_W'(i_seg.segment);

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_seg.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Angle products, quotient estimates and reduced angles.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_p0    <= n_p0;
            r_s1_p1    <= n_p0 + step_ext;
            r_s1_index <= i_cfg.base_index + (seg_idx << 2) + (seg_idx << 1);

            r_s2_p0    <= r_s1_p0;
            r_s2_p1    <= r_s1_p1;
            r_s2_q0    <= quot_est(r_s1_p0);
            r_s2_q1    <= quot_est(r_s1_p1);
            r_s2_index <= r_s1_index;

            r_s3_a0    <= rem_fix(r_s2_p0, r_s2_q0);
            r_s3_a1    <= rem_fix(r_s2_p1, r_s2_q1);
            r_s3_index <= r_s2_index;
        end
    end

    // Table lookups for both angles feed the queue.
    assign o_job_valid      = r_s3_valid;
    assign o_job.sin0       = asvg_pkg::trig_of(r_s3_a0);
    assign o_job.cos0       = asvg_pkg::trig_of(asvg_pkg::quarter_ahead(r_s3_a0));
    assign o_job.sin1       = asvg_pkg::trig_of(r_s3_a1);
    assign o_job.cos1       = asvg_pkg::trig_of(asvg_pkg::quarter_ahead(r_s3_a1));
    assign o_job.index_base = r_s3_index;

endmodule

@@ rtl/core/asvg_queue.sv @@
module asvg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_valid,
    output logic               o_push_ready,
    input  asvg_pkg::t_seg_job i_push_data,
    output logic               o_pop_valid,
    input  logic               i_pop_ready,
    output asvg_pkg::t_seg_job o_pop_data
);

    localparam int DEPTH = asvg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    asvg_pkg::t_seg_job r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ rtl/core/asvg_back.sv @@
module asvg_back #(
    parameter int COORD_WIDTH = asvg_pkg::COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  asvg_pkg::t_cfg     i_cfg,
    input  logic               i_job_valid,
    input  asvg_pkg::t_seg_job i_job,
    output logic               o_job_ready,
    asvg_vtx_if.source         o_vtx
);

    localparam int TERM_W = asvg_pkg::MULT_W + 1 - asvg_pkg::ROUND_SHIFT;
    localparam int SUM_W  = ((COORD_WIDTH > TERM_W) ? COORD_WIDTH : TERM_W) + 2;
    localparam longint SAT_HI = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic                              out_adv;
    logic                              b1_adv;
    logic                              issue;
    logic                              at_last;
    logic                              use_a1;
    logic                              outer;
    asvg_pkg::t_trig                   trig_x;
    asvg_pkg::t_trig                   trig_y;
    logic [asvg_pkg::RSUM_W-1:0]       rad_x;
    logic [asvg_pkg::RSUM_W-1:0]       rad_y;

    logic [asvg_pkg::CORNER_W-1:0]     r_corner;

    logic                              r_b1_valid;
    logic [asvg_pkg::MULT_W-1:0]       r_b1_prod_x;
    logic [asvg_pkg::MULT_W-1:0]       r_b1_prod_y;
    logic                              r_b1_neg_x;
    logic                              r_b1_neg_y;
    logic [asvg_pkg::INDEX_W-1:0]      r_b1_index;
    logic [asvg_pkg::CORNER_W-1:0]     r_b1_corner;
    logic                              r_b1_last;

    logic                              r_out_valid;
    logic signed [COORD_WIDTH-1:0]     r_out_x;
    logic signed [COORD_WIDTH-1:0]     r_out_y;
    logic [asvg_pkg::INDEX_W-1:0]      r_out_index;
    logic [asvg_pkg::CORNER_W-1:0]     r_out_corner;
    logic [asvg_pkg::COLOR_W-1:0]      r_out_color;
    logic                              r_out_last;

    // Rounded product given the trig sign, added to the center and saturated.
    function automatic logic signed [COORD_WIDTH-1:0] place(
        input logic signed [asvg_pkg::CENTER_W-1:0] center,
        input logic                                 neg,
        input logic [asvg_pkg::MULT_W-1:0]          prod
    );
        logic [asvg_pkg::MULT_W:0] rounded;
        logic signed [SUM_W-1:0]   term;
        logic signed [SUM_W-1:0]   v;
        rounded = {1'b0, prod} + (asvg_pkg::MULT_W+1)'(asvg_pkg::ROUND_HALF);
        term    = $signed(SUM_W'(rounded >> asvg_pkg::ROUND_SHIFT));
        v       = SUM_W'(center) + (neg ? -term : term);
        if (v > SUM_W'(SAT_HI)) begin
            v = SUM_W'(SAT_HI);
        end
        if (v < SUM_W'(SAT_LO)) begin
            v = SUM_W'(SAT_LO);
        end
        return COORD_WIDTH'(v);
    endfunction

    // Output register frees when taken; the multiply stage frees into it.
    assign out_adv     = !r_out_valid || o_vtx.ready;
    assign b1_adv      = !r_b1_valid || out_adv;
    assign issue       = i_job_valid && b1_adv;
    assign at_last     = (r_corner == asvg_pkg::CORNER_W'(asvg_pkg::LAST_CORNER));
    assign o_job_ready = b1_adv && at_last;

    // Corners two to four use the far angle; odd corners lie on the outer edge.
    assign use_a1 = (r_corner >= asvg_pkg::CORNER_W'(2)) && (r_corner <= asvg_pkg::CORNER_W'(4));
    assign outer  = r_corner[0];
    assign trig_x = use_a1 ? i_job.cos1 : i_job.cos0;
    assign trig_y = use_a1 ? i_job.sin1 : i_job.sin0;
    assign rad_x  = asvg_pkg::RSUM_W'(i_cfg.scale_x)
                  + (outer ? asvg_pkg::RSUM_W'(i_cfg.thickness) : '0);
    assign rad_y  = asvg_pkg::RSUM_W'(i_cfg.scale_y)
                  + (outer ? asvg_pkg::RSUM_W'(i_cfg.thickness) : '0);

    // Control: corner counter and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner    <= '0;
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_corner <= at_last ? '0 : r_corner + 1'b1;
            end
            if (b1_adv) begin
                r_b1_valid <= issue;
            end
            if (out_adv) begin
                r_out_valid <= r_b1_valid;
            end
        end
    end

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (b1_adv) begin
            r_b1_prod_x <= asvg_pkg::MULT_W'(trig_x.mag) * asvg_pkg::MULT_W'(rad_x);
            r_b1_prod_y <= asvg_pkg::MULT_W'(trig_y.mag) * asvg_pkg::MULT_W'(rad_y);
            r_b1_neg_x  <= trig_x.neg;
            r_b1_neg_y  <= trig_y.neg;
            r_b1_index  <= i_job.index_base + asvg_pkg::INDEX_W'(r_corner);
            r_b1_corner <= r_corner;
            r_b1_last   <= at_last;
        end
    end

    // Output register: round, offset and saturate.
    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out_x      <= place(i_cfg.center_x, r_b1_neg_x, r_b1_prod_x);
            r_out_y      <= place(i_cfg.center_y, r_b1_neg_y, r_b1_prod_y);
            r_out_index  <= r_b1_index;
            r_out_corner <= r_b1_corner;
            r_out_color  <= i_cfg.color_rgb;
            r_out_last   <= r_b1_last;
        end
    end

    assign o_vtx.valid        = r_out_valid;
    assign o_vtx.vertex_x     = r_out_x;
    assign o_vtx.vertex_y     = r_out_y;
    assign o_vtx.vertex_index = r_out_index;
    assign o_vtx.corner       = r_out_corner;
    assign o_vtx.red          = r_out_color[3*asvg_pkg::CHAN_W-1:2*asvg_pkg::CHAN_W];
    assign o_vtx.green        = r_out_color[2*asvg_pkg::CHAN_W-1:asvg_pkg::CHAN_W];
    assign o_vtx.blue         = r_out_color[asvg_pkg::CHAN_W-1:0];
    assign o_vtx.last         = r_out_last;

endmodule

@@ rtl/core/annulus_segment_vertex_generator.sv @@
// Channel   Direction  Carries                               Transfer when
// i_seg     in         segment number (7 bits)               valid && ready
// o_vtx     out        x, y, index, corner, color, last      valid && ready
// i_cfg_*   in         register index and data, write only   i_cfg_we
//
// Each segment yields six vertices, one per cycle while the output is not stalled;
// the back's corner counter steps through them ahead of its one multiply stage.
// A segment passes the front stages, queue, multiply stage and output register.
// Synchronous active-low reset clears the pipelines and queue and loads the
// register reset values; no clearing pass follows.
// A stalled output holds the back; a two-entry queue lets the front keep taking
// segments until it fills.
module annulus_segment_vertex_generator #(
    parameter int COORD_WIDTH = asvg_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [asvg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [asvg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    asvg_seg_if.sink                         i_seg,
    asvg_vtx_if.source                       o_vtx
);

    asvg_pkg::t_cfg     r_cfg;
    logic               job_valid;
    logic               job_ready;
    asvg_pkg::t_seg_job job;
    logic               pop_valid;
    logic               pop_ready;
    asvg_pkg::t_seg_job pop_job;

    // Configuration registers; the segment count is kept as its angular step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x   <= '0;
            r_cfg.center_y   <= '0;
            r_cfg.scale_x    <= asvg_pkg::RADIUS_W'(asvg_pkg::RESET_SCALE);
            r_cfg.scale_y    <= asvg_pkg::RADIUS_W'(asvg_pkg::RESET_SCALE);
            r_cfg.thickness  <= '0;
            r_cfg.step       <= asvg_pkg::RESET_STEP;
            r_cfg.color_rgb  <= asvg_pkg::COLOR_W'(asvg_pkg::RESET_COLOR);
            r_cfg.base_index <= '0;
        end else if (i_cfg_we) begin
            case (asvg_pkg::t_cfg_reg'(i_cfg_index))
                asvg_pkg::CFG_CENTER_X: begin
                    r_cfg.center_x <= i_cfg_data[asvg_pkg::CENTER_W-1:0];
                end
                asvg_pkg::CFG_CENTER_Y: begin
                    r_cfg.center_y <= i_cfg_data[asvg_pkg::CENTER_W-1:0];
                end
                asvg_pkg::CFG_SCALE_X: begin
                    r_cfg.scale_x <= i_cfg_data[asvg_pkg::RADIUS_W-1:0];
                end
                asvg_pkg::CFG_SCALE_Y: begin
                    r_cfg.scale_y <= i_cfg_data[asvg_pkg::RADIUS_W-1:0];
                end
                asvg_pkg::CFG_THICKNESS: begin
                    r_cfg.thickness <= i_cfg_data[asvg_pkg::RADIUS_W-1:0];
                end
                asvg_pkg::CFG_SEGMENT_COUNT: begin
                    r_cfg.step <= asvg_pkg::STEP_TAB[i_cfg_data[asvg_pkg::COUNT_W-1:0]];
                end
                asvg_pkg::CFG_COLOR_RGB: begin
                    r_cfg.color_rgb <= i_cfg_data[asvg_pkg::COLOR_W-1:0];
                end
                asvg_pkg::CFG_BASE_INDEX: begin
                    r_cfg.base_index <= i_cfg_data[asvg_pkg::INDEX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    asvg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_seg       (i_seg),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_ready (job_ready)
    );

    asvg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid),
        .o_push_ready (job_ready),
        .i_push_data  (job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_job)
    );

    asvg_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_ready (pop_ready),
        .o_vtx       (o_vtx)
    );

endmodule
